[design/rrts_pkg.sv]
// shared types, constants and command structs of the round-robin task scheduler
package rrts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int OP_W      = 3;
  localparam int ID_W      = 4;

  localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
  localparam logic [OP_W-1:0] OP_INIT     = 3'd1;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd2;
  localparam logic [OP_W-1:0] OP_BLOCK    = 3'd3;
  localparam logic [OP_W-1:0] OP_WAKE     = 3'd4;

  typedef enum logic [1:0] {
    ST_ABSENT  = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NONE    = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_RESCHED,
    S_PREV,
    S_WALK,
    S_LINK2,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RA_ID,
    RA_HEAD,
    RA_RUN,
    RA_LINK
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_ID,
    WA_HEAD,
    WA_PREV,
    WA_WALK
  } wr_sel_t;

  typedef struct packed {
    logic        latch;
    rd_sel_t     rd_sel;
    logic        lk_rd_head;
    logic        st_we;
    wr_sel_t     st_wsel;
    slot_state_t st_wdata;
    logic        lk_we;
    logic        lk_wa_head;
    logic        lk_wd_link;
    logic        set_head;
    logic        do_init;
    logic        resched_start;
    logic        walk_load;
    logic        walk_first;
    logic        walk_found;
    logic        walk_none;
    logic        status_we;
    status_t     status;
    logic        out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_ok;
    logic            started;
    logic            head_pres;
    logic            run_pres;
    logic            run_is_id;
    slot_state_t     st_rd;
    logic            cnt_full;
    logic            out_busy;
  } dp_stat_t;

endpackage

[design/round_robin_task_scheduler_unit.sv]
// top level of the round-robin task scheduler
//
// in channel: in_operation (add, init, schedule, block, wake) and in_task_id,
// taken when in_valid is high and in_stall is low. out channel: one word per
// operation with the running task, the switch report and a status code, taken
// when out_valid is high and out_stall is low.
// one operation at a time; in_stall is low only while the sequencer is idle.
// an operation passes decode, then execute for add, block and wake, then a
// second link write for an add to a non-empty ring; schedule and block of the
// running task then reschedule: a task still running is made ready and the
// ring is walked from the slot after it (from the head with no running task)
// over 1 to 16 slots; the walk reads one slot a cycle from the link and state
// stores. the sequencer returns to idle, so in_stall falls, in the same cycle
// as out_valid rises.
// a new operation is accepted while the previous word still waits; if the
// receiver stalls, the next word is held back until the output is free.
// reset (synchronous, rst_n low) empties the ring, marks all slots absent and
// clears the running task; no clearing pass is needed.
module round_robin_task_scheduler_unit
  import rrts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] in_operation,
  input  logic [ID_W-1:0] in_task_id,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [ID_W-1:0] out_current_task,
  output logic            out_current_valid,
  output logic            out_switched,
  output logic [ID_W-1:0] out_previous_task,
  output logic [1:0]      out_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_task_id        (in_task_id),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_current_task  (out_current_task),
    .out_current_valid (out_current_valid),
    .out_switched      (out_switched),
    .out_previous_task (out_previous_task),
    .out_status        (out_status)
  );

endmodule

[design/rrts_ctrl.sv]
// controller state machine of the round-robin task scheduler
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.rd_sel = RA_ID;
        unique case (stat.op) inside
          OP_ADD: begin
            cmd.lk_rd_head = 1'b1;
            if (!stat.id_ok) begin
              cmd.status_we = 1'b1;
              cmd.status    = STATUS_IGNORED;
              state_nxt     = S_FINISH;
            end else begin
              state_nxt = S_EXEC;
            end
          end
          OP_INIT: begin
            if (!stat.head_pres || stat.started) begin
              cmd.status_we = 1'b1;
              cmd.status    = STATUS_IGNORED;
            end else begin
              cmd.do_init  = 1'b1;
              cmd.st_we    = 1'b1;
              cmd.st_wsel  = WA_HEAD;
              cmd.st_wdata = ST_RUNNING;
            end
            state_nxt = S_FINISH;
          end
          OP_SCHEDULE: begin
            if (!stat.started) begin
              cmd.status_we = 1'b1;
              cmd.status    = STATUS_IGNORED;
              state_nxt     = S_FINISH;
            end else begin
              state_nxt = S_RESCHED;
            end
          end
          OP_BLOCK, OP_WAKE: begin
            if (!stat.id_ok) begin
              cmd.status_we = 1'b1;
              cmd.status    = STATUS_IGNORED;
              state_nxt     = S_FINISH;
            end else begin
              state_nxt = S_EXEC;
            end
          end
          default: begin
            cmd.status_we = 1'b1;
            cmd.status    = STATUS_IGNORED;
            state_nxt     = S_FINISH;
          end
        endcase
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
        if (stat.st_rd == ST_ABSENT) begin
          if (stat.op == OP_ADD) begin
            cmd.st_we      = 1'b1;
            cmd.st_wsel    = WA_ID;
            cmd.st_wdata   = ST_READY;
            cmd.lk_we      = 1'b1;
            cmd.lk_wd_link = stat.head_pres;
            if (stat.head_pres) begin
              state_nxt = S_LINK2;
            end else begin
              cmd.set_head = 1'b1;
            end
          end else begin
            cmd.status_we = 1'b1;
            cmd.status    = STATUS_IGNORED;
          end
        end else begin
          unique case (stat.op)
            OP_BLOCK: begin
              cmd.st_we    = 1'b1;
              cmd.st_wsel  = WA_ID;
              cmd.st_wdata = ST_BLOCKED;
              if (stat.run_pres && stat.run_is_id) begin
                state_nxt = S_RESCHED;
              end
            end
            OP_WAKE: begin
              if (stat.st_rd == ST_BLOCKED) begin
                cmd.st_we    = 1'b1;
                cmd.st_wsel  = WA_ID;
                cmd.st_wdata = ST_READY;
              end
            end
            default: begin
              cmd.status_we = 1'b1;
              cmd.status    = STATUS_IGNORED;
            end
          endcase
        end
      end
      S_RESCHED: begin
        cmd.resched_start = 1'b1;
        if (stat.run_pres) begin
          cmd.rd_sel = RA_RUN;
          state_nxt  = S_PREV;
        end else begin
          cmd.rd_sel     = RA_HEAD;
          cmd.walk_load  = 1'b1;
          cmd.walk_first = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_PREV: begin
        if (stat.st_rd == ST_RUNNING) begin
          cmd.st_we    = 1'b1;
          cmd.st_wsel  = WA_PREV;
          cmd.st_wdata = ST_READY;
        end
        cmd.rd_sel     = RA_LINK;
        cmd.walk_load  = 1'b1;
        cmd.walk_first = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        cmd.rd_sel = RA_LINK;
        if (stat.st_rd == ST_READY) begin
          cmd.walk_found = 1'b1;
          cmd.st_we      = 1'b1;
          cmd.st_wsel    = WA_WALK;
          cmd.st_wdata   = ST_RUNNING;
          state_nxt      = S_FINISH;
        end else if (stat.cnt_full) begin
          cmd.walk_none = 1'b1;
          cmd.status_we = 1'b1;
          cmd.status    = STATUS_NONE;
          state_nxt     = S_FINISH;
        end else begin
          cmd.walk_load = 1'b1;
        end
      end
      S_LINK2: begin
        cmd.lk_we      = 1'b1;
        cmd.lk_wa_head = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[design/rrts_dp.sv]
// datapath of the round-robin task scheduler: ring and state stores, walk and result registers
module rrts_dp
  import rrts_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [OP_W-1:0] in_operation,
  input  logic [ID_W-1:0] in_task_id,
  input  dp_cmd_t         cmd,
  output dp_stat_t        stat,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [ID_W-1:0] out_current_task,
  output logic            out_current_valid,
  output logic            out_switched,
  output logic [ID_W-1:0] out_previous_task,
  output logic [1:0]      out_status
);

  logic [SLOT_W-1:0] link_mem_r [MAX_TASKS];
  slot_state_t       st_mem_r   [MAX_TASKS];
  logic [MAX_TASKS-1:0] st_vld_r;

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [SLOT_W-1:0] head_r, run_r, prev_r, walk_r, prev_out_r;
  logic              head_pres_r, run_pres_r, started_r, had_run_r, sw_r;
  logic [CNT_W-1:0]  cnt_r;
  status_t           status_r;
  logic [SLOT_W-1:0] link_rd_r;
  slot_state_t       st_rd_r;

  logic              out_valid_r, out_cur_valid_r, out_sw_r;
  logic [ID_W-1:0]   out_cur_task_r, out_prev_task_r;
  status_t           out_status_r;

  logic [SLOT_W-1:0] id_slot, rd_addr, lk_raddr, st_waddr, lk_waddr, lk_wdata;
  logic              id_ok, out_take;

  assign id_slot  = SLOT_W'(id_r);
  assign id_ok    = (int'(id_r) < MAX_TASKS);
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    case (cmd.rd_sel)
      RA_ID:   rd_addr = id_slot;
      RA_HEAD: rd_addr = head_r;
      RA_RUN:  rd_addr = run_r;
      default: rd_addr = link_rd_r;
    endcase
    case (cmd.st_wsel)
      WA_ID:   st_waddr = id_slot;
      WA_HEAD: st_waddr = head_r;
      WA_PREV: st_waddr = prev_r;
      default: st_waddr = walk_r;
    endcase
  end

  assign lk_raddr = cmd.lk_rd_head ? head_r : rd_addr;
  assign lk_waddr = cmd.lk_wa_head ? head_r : id_slot;
  assign lk_wdata = cmd.lk_wd_link ? link_rd_r : id_slot;

  // ring links
  always_ff @(posedge clk) begin
    if (cmd.lk_we) begin
      link_mem_r[lk_waddr] <= lk_wdata;
    end
    link_rd_r <= link_mem_r[lk_raddr];
  end

  // slot states, write-first on a same-cycle hit
  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      st_mem_r[st_waddr] <= cmd.st_wdata;
    end
    if (cmd.st_we && (st_waddr == rd_addr)) begin
      st_rd_r <= cmd.st_wdata;
    end else if (st_vld_r[rd_addr]) begin
      st_rd_r <= st_mem_r[rd_addr];
    end else begin
      st_rd_r <= ST_ABSENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
    end else if (cmd.st_we) begin
      st_vld_r[st_waddr] <= 1'b1;
    end
  end

  // scheduler registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      head_pres_r <= 1'b0;
      run_r       <= '0;
      run_pres_r  <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      if (cmd.set_head) begin
        head_r      <= id_slot;
        head_pres_r <= 1'b1;
      end
      if (cmd.do_init) begin
        run_r      <= head_r;
        run_pres_r <= 1'b1;
        started_r  <= 1'b1;
      end
      if (cmd.walk_found) begin
        run_r      <= walk_r;
        run_pres_r <= 1'b1;
      end
      if (cmd.walk_none) begin
        run_r      <= '0;
        run_pres_r <= 1'b0;
      end
    end
  end

  // per-operation work registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= in_operation;
      id_r       <= in_task_id;
      sw_r       <= 1'b0;
      prev_out_r <= '0;
      status_r   <= STATUS_OK;
    end
    if (cmd.do_init) begin
      sw_r <= 1'b1;
    end
    if (cmd.status_we) begin
      status_r <= cmd.status;
    end
    if (cmd.resched_start) begin
      prev_r    <= run_r;
      had_run_r <= run_pres_r;
    end
    if (cmd.walk_load) begin
      walk_r <= rd_addr;
      cnt_r  <= cmd.walk_first ? CNT_W'(1) : cnt_r + CNT_W'(1);
    end
    if (cmd.walk_found) begin
      sw_r       <= !had_run_r || (walk_r != prev_r);
      prev_out_r <= (had_run_r && (walk_r != prev_r)) ? prev_r : '0;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cur_task_r  <= run_pres_r ? ID_W'(run_r) : '0;
      out_cur_valid_r <= run_pres_r;
      out_sw_r        <= sw_r;
      out_prev_task_r <= sw_r ? ID_W'(prev_out_r) : '0;
      out_status_r    <= status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_task  = out_cur_task_r;
  assign out_current_valid = out_cur_valid_r;
  assign out_switched      = out_sw_r;
  assign out_previous_task = out_prev_task_r;
  assign out_status        = out_status_r;

  assign stat.op        = op_r;
  assign stat.id_ok     = id_ok;
  assign stat.started   = started_r;
  assign stat.head_pres = head_pres_r;
  assign stat.run_pres  = run_pres_r;
  assign stat.run_is_id = id_ok && (run_r == id_slot);
  assign stat.st_rd     = st_rd_r;
  assign stat.cnt_full  = (cnt_r == CNT_W'(MAX_TASKS));
  assign stat.out_busy  = out_valid_r && out_stall;

  a_run_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    run_pres_r |-> started_r)
    else $error("task running before init");

  a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
    head_pres_r |=> head_pres_r)
    else $error("ring head lost");

  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sw_r |-> out_status_r == STATUS_OK && out_cur_valid_r)
    else $error("switch reported without a running task");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_load && !cmd.walk_first |-> cnt_r < CNT_W'(MAX_TASKS))
    else $error("ring walk past its bound");

endmodule
